/* rtl/gcvs_pkg.sv */
// gcvs_pkg: shared types, widths and codes of the gc victim block selector
// no dependencies; used by the interfaces, controller, datapath and top level
package gcvs_pkg;

  localparam int unsigned POS_W  = 10;
  localparam int unsigned PG_W   = 11;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned AB_W   = 2 * PG_W;
  localparam int unsigned SC_W   = AB_W + WORD_W;

  // number of block positions, the position wraps to zero after the last
  localparam logic [POS_W:0]  NUM_BLOCKS = 11'd1024;
  // largest page capacity, the capacity value in use is clamped to it
  localparam logic [PG_W-1:0] MAX_PAGES   = 11'd1024;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGES_IN_BLOCK = 1'd1;

  localparam logic POLICY_GREEDY = 1'b0;
  localparam logic [PG_W-1:0] PAGES_RESET = 11'd256;

  typedef struct packed {
    logic              block_clean;
    logic [PG_W-1:0]   used_pages;
    logic [PG_W-1:0]   stale_pages;
    logic [WORD_W-1:0] wear_count;
    logic [WORD_W-1:0] modified_time;
    logic [WORD_W-1:0] current_time;
    logic [POS_W-1:0]  active_block;
    logic              final_block;
  } in_item_t;

  typedef struct packed {
    logic             victim_found;
    logic [POS_W-1:0] victim_index;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_DECIDE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_last;
    logic out_busy;
  } status_t;

endpackage

/* rtl/gcvs_in_if.sv */
// gcvs_in_if: valid/ready channel that carries one block descriptor item
// depends on gcvs_pkg
interface gcvs_in_if;
  logic                valid;
  logic                ready;
  gcvs_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/gcvs_out_if.sv */
// gcvs_out_if: valid/ready channel that carries one victim result item
// depends on gcvs_pkg
interface gcvs_out_if;
  logic                valid;
  logic                ready;
  gcvs_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/gc_victim_block_selector.sv */
// gc_victim_block_selector: each item steps through accept, two multiply
// stages and decide; the two-stage cross-multiplication of the scores sets
// that sequence, and a final item's result is registered when it commits
// a final item held in decide waits while the previous result is untaken
// reset (rst_ni low, asynchronous) gives greedy mode, 256 pages per block,
// an empty scan at position zero and no result pending
module gc_victim_block_selector (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [gcvs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gcvs_pkg::PG_W-1:0]        cfg_data_i,
  // block descriptor items in, victim result items out
  gcvs_in_if.sink                          in_i,
  gcvs_out_if.source                       out_o
);

  // command and status between sequencer and datapath
  gcvs_pkg::cmd_t    cmd;
  gcvs_pkg::status_t st;

  // sequencer: idle -> first multiply -> second multiply -> decide
  // ready is only raised in idle, one item is in flight at a time
  gcvs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd),
    .st_i       (st)
  );

  // datapath: item capture, score products, best-block tracking and the
  // output register that lets the next scan start while a result waits
  gcvs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (in_i.data),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

endmodule

/* rtl/gcvs_ctrl.sv */
// gcvs_ctrl: sequencer that steps one item through load, two multiply
// stages and the decision; depends on gcvs_pkg
module gcvs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output gcvs_pkg::cmd_t    cmd_o,
  input  gcvs_pkg::status_t st_i
);

  gcvs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gcvs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      gcvs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = gcvs_pkg::ST_MUL1;
        end
      end
      gcvs_pkg::ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = gcvs_pkg::ST_MUL2;
      end
      gcvs_pkg::ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = gcvs_pkg::ST_DECIDE;
      end
      gcvs_pkg::ST_DECIDE: begin
        // a final item waits here until the output register is free
        if (!(st_i.is_last && st_i.out_busy)) begin
          cmd_o.commit = 1'b1;
          state_d      = gcvs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = gcvs_pkg::ST_IDLE;
      end
    endcase
  end

  a_load_to_mul1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == gcvs_pkg::ST_MUL1))
    else $error("accepted item did not enter the first multiply stage");

  a_mul2_after_mul1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gcvs_pkg::ST_MUL1) |=> (state_q == gcvs_pkg::ST_MUL2))
    else $error("multiply stages out of order");

  a_commit_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> !(st_i.is_last && st_i.out_busy))
    else $error("final item committed while result still pending");

endmodule

/* rtl/gcvs_dp.sv */
// gcvs_dp: item register, cross-multiplied score stages, best-block state,
// configuration registers and result register; depends on gcvs_pkg
module gcvs_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [gcvs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [gcvs_pkg::PG_W-1:0]           cfg_data_i,
  input  gcvs_pkg::in_item_t                  item_i,
  input  gcvs_pkg::cmd_t                      cmd_i,
  output gcvs_pkg::status_t                   st_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output gcvs_pkg::out_item_t                 out_data_o
);

  localparam int unsigned PG_W   = gcvs_pkg::PG_W;
  localparam int unsigned POS_W  = gcvs_pkg::POS_W;
  localparam int unsigned WORD_W = gcvs_pkg::WORD_W;
  localparam int unsigned AB_W   = gcvs_pkg::AB_W;
  localparam int unsigned SC_W   = gcvs_pkg::SC_W;

  // configuration
  logic            policy_q;
  logic [PG_W-1:0] pages_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= gcvs_pkg::POLICY_GREEDY;
      pages_q  <= gcvs_pkg::PAGES_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gcvs_pkg::CFG_POLICY_MODE:    policy_q <= cfg_data_i[0];
        gcvs_pkg::CFG_PAGES_IN_BLOCK: pages_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // item register, payload only
  gcvs_pkg::in_item_t item_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
  end

  // best-block state
  logic              have_q, have_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [POS_W-1:0]  bpos_q, bpos_d;
  logic [PG_W-1:0]   binv_q, binv_d;
  logic [PG_W-1:0]   bval_q, bval_d;
  logic [WORD_W-1:0] bage_q, bage_d;
  logic [WORD_W-1:0] bwear_q, bwear_d;

  // capacity clamp and free page counts
  logic [PG_W-1:0] cap;
  logic [PG_W-1:0] n_cand;
  logic [PG_W-1:0] n_best;

  assign cap    = (pages_q > gcvs_pkg::MAX_PAGES) ? gcvs_pkg::MAX_PAGES : pages_q;
  assign n_cand = (item_q.used_pages >= cap) ? '0 : cap - item_q.used_pages;
  assign n_best = (bval_q >= cap) ? '0 : cap - bval_q;

  // stage one: age and the two page products
  logic [WORD_W-1:0] age_q;
  logic [AB_W-1:0]   a_q;
  logic [AB_W-1:0]   b_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      age_q <= item_q.current_time - item_q.modified_time;
      a_q   <= {{(AB_W-PG_W){1'b0}}, n_cand} * {{(AB_W-PG_W){1'b0}}, bval_q};
      b_q   <= {{(AB_W-PG_W){1'b0}}, n_best} * {{(AB_W-PG_W){1'b0}}, item_q.used_pages};
    end
  end

  // stage two: full cross-multiplied scores
  logic [SC_W-1:0] lhs_q;
  logic [SC_W-1:0] rhs_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul2) begin
      lhs_q <= {{WORD_W{1'b0}}, a_q} * {{AB_W{1'b0}}, age_q};
      rhs_q <= {{WORD_W{1'b0}}, b_q} * {{AB_W{1'b0}}, bage_q};
    end
  end

  // decision
  logic cand;
  logic gt;
  logic eq;
  logic take;
  logic [POS_W:0] pos_sum;

  always_comb begin
    cand = !item_q.block_clean && (pos_q != item_q.active_block);
    if (policy_q == gcvs_pkg::POLICY_GREEDY) begin
      gt = item_q.stale_pages > binv_q;
      eq = item_q.stale_pages == binv_q;
    end else if (item_q.used_pages == '0 && bval_q == '0) begin
      gt = 1'b0;
      eq = 1'b1;
    end else if (item_q.used_pages == '0) begin
      gt = 1'b1;
      eq = 1'b0;
    end else if (bval_q == '0) begin
      gt = 1'b0;
      eq = 1'b0;
    end else begin
      gt = lhs_q > rhs_q;
      eq = lhs_q == rhs_q;
    end
    take = cand && (!have_q || gt || (eq && (item_q.wear_count < bwear_q)));

    pos_sum = {1'b0, pos_q} + {{POS_W{1'b0}}, 1'b1};

    have_d  = have_q;
    pos_d   = pos_q;
    bpos_d  = bpos_q;
    binv_d  = binv_q;
    bval_d  = bval_q;
    bage_d  = bage_q;
    bwear_d = bwear_q;
    if (cmd_i.commit) begin
      if (take) begin
        have_d  = 1'b1;
        bpos_d  = pos_q;
        binv_d  = item_q.stale_pages;
        bval_d  = item_q.used_pages;
        bage_d  = age_q;
        bwear_d = item_q.wear_count;
      end
      pos_d = (pos_sum >= gcvs_pkg::NUM_BLOCKS) ? '0 : pos_sum[POS_W-1:0];
      if (item_q.final_block) begin
        pos_d  = '0;
        have_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q  <= 1'b0;
      pos_q   <= '0;
      bpos_q  <= '0;
      binv_q  <= '0;
      bval_q  <= '0;
      bage_q  <= '0;
      bwear_q <= '0;
    end else begin
      have_q  <= have_d;
      pos_q   <= pos_d;
      bpos_q  <= bpos_d;
      binv_q  <= binv_d;
      bval_q  <= bval_d;
      bage_q  <= bage_d;
      bwear_q <= bwear_d;
    end
  end

  // result register
  logic                out_valid_q, out_valid_d;
  gcvs_pkg::out_item_t out_data_q, out_data_d;
  logic                found;

  always_comb begin
    found       = have_q || take;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.commit && item_q.final_block) begin
      out_valid_d             = 1'b1;
      out_data_d.victim_found = found;
      out_data_d.victim_index = found ? bpos_d : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;
  assign st_o.is_last    = item_q.final_block;
  assign st_o.out_busy   = out_valid_q && !out_ready_i;

  a_scan_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && item_q.final_block) |=> (!have_q && pos_q == '0))
    else $error("scan state not cleared after final item");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.commit && item_q.final_block))
    else $error("result appeared without a final item");

  a_none_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_data_q.victim_found) |-> (out_data_q.victim_index == '0))
    else $error("no-victim result carries a nonzero index");

endmodule

/* bench/tb_gc_victim_block_selector.sv */
`timescale 1ns / 100ps
// tb_gc_victim_block_selector: self-checking bench for the gc victim block selector
// drives descriptor scans and register writes, predicts each victim and compares it
// depends on gcvs_pkg, gcvs_in_if, gcvs_out_if and gc_victim_block_selector
module tb_gc_victim_block_selector;
  import gcvs_pkg::*;

  localparam int unsigned HALF_PERIOD   = 6;
  localparam int unsigned RESET_CYCLES  = 12;
  // cycles after the last accepted item before the block counts as idle
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned TIMEOUT_NS    = 2_000_000;
  localparam int unsigned ITEM_TARGET   = 1250;
  localparam logic        POLICY_COST_BENEFIT = 1'b1;

  typedef enum logic [1:0] {
    STEP_ITEM,
    STEP_WRITE,
    STEP_DRAIN,
    STEP_PACE
  } step_kind_e;

  // one entry of the driver's work list
  typedef struct {
    step_kind_e           kind;
    in_item_t             desc;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [PG_W-1:0]      reg_val;
    int unsigned          idle_pct;
    int unsigned          stall_pct;
  } step_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                 cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx  = '0;
  logic [PG_W-1:0]      cfg_data = '0;

  gcvs_in_if  desc_if ();
  gcvs_out_if victim_if ();

  gc_victim_block_selector dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (desc_if),
    .out_o      (victim_if)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // work list, expected victims and run bookkeeping
  step_t       pending[$];
  out_item_t   victim_q[$];
  int unsigned items_queued = 0;
  int unsigned mismatches   = 0;
  int unsigned idle_pct     = 0;
  int unsigned stall_pct    = 0;
  int unsigned quiet_cycles = SETTLE_CYCLES;
  int unsigned hold_cycles  = 0;

  // predictor copy of the registers and the scan state, at reset values
  logic              mdl_mode     = POLICY_GREEDY;
  logic [PG_W-1:0]   mdl_pages    = PAGES_RESET;
  logic [POS_W-1:0]  scan_pos     = '0;
  logic              holding      = 1'b0;
  logic [POS_W-1:0]  lead_pos     = '0;
  logic [PG_W-1:0]   lead_invalid = '0;
  logic [PG_W-1:0]   lead_valid   = '0;
  logic [WORD_W-1:0] lead_age     = '0;
  logic [WORD_W-1:0] lead_wear    = '0;

  // free pages of a block, zero once valid pages reach the capacity
  function automatic logic [63:0] free_of(logic [63:0] cap, logic [PG_W-1:0] v);
    return (64'(v) >= cap) ? 64'd0 : cap - 64'(v);
  endfunction

  // runs one accepted descriptor through the scan and queues the victim on a final item
  function automatic void predict_victim(in_item_t d);
    logic [WORD_W-1:0] age;
    logic [63:0]       cap;
    logic [63:0]       lhs;
    logic [63:0]       rhs;
    int                order;
    logic              take;
    logic [POS_W:0]    nxt;
    out_item_t         res;
    age = d.current_time - d.modified_time;
    cap = (mdl_pages > MAX_PAGES) ? 64'(MAX_PAGES) : 64'(mdl_pages);
    if (!d.block_clean && scan_pos != d.active_block) begin
      if (!holding) begin
        take = 1'b1;
      end else begin
        if (mdl_mode == POLICY_GREEDY) begin
          order = (d.stale_pages > lead_invalid) ? 1 :
                  (d.stale_pages < lead_invalid) ? -1 : 0;
        end else if (d.used_pages == 0 && lead_valid == 0) begin
          order = 0;
        end else if (d.used_pages == 0) begin
          order = 1;
        end else if (lead_valid == 0) begin
          order = -1;
        end else begin
          // cross-multiplied score: free * age / valid on both sides
          lhs = free_of(cap, d.used_pages) * 64'(age) * 64'(lead_valid);
          rhs = free_of(cap, lead_valid) * 64'(lead_age) * 64'(d.used_pages);
          order = (lhs > rhs) ? 1 : (lhs < rhs) ? -1 : 0;
        end
        take = (order > 0) || (order == 0 && d.wear_count < lead_wear);
      end
      if (take) begin
        holding      = 1'b1;
        lead_pos     = scan_pos;
        lead_invalid = d.stale_pages;
        lead_valid   = d.used_pages;
        lead_age     = age;
        lead_wear    = d.wear_count;
      end
    end
    nxt = scan_pos + 1'b1;
    if (nxt >= NUM_BLOCKS) nxt = '0;
    scan_pos = nxt[POS_W-1:0];
    if (d.final_block) begin
      res.victim_found = holding;
      res.victim_index = holding ? lead_pos : '0;
      victim_q.push_back(res);
      scan_pos = '0;
      holding  = 1'b0;
    end
  endfunction

  function automatic void add_desc(logic clean, logic [PG_W-1:0] v, logic [PG_W-1:0] inv,
                                   logic [WORD_W-1:0] wear, logic [WORD_W-1:0] mtime,
                                   logic [WORD_W-1:0] now_t, logic [POS_W-1:0] act,
                                   logic last);
    step_t s;
    s.kind               = STEP_ITEM;
    s.desc.block_clean   = clean;
    s.desc.used_pages    = v;
    s.desc.stale_pages   = inv;
    s.desc.wear_count    = wear;
    s.desc.modified_time = mtime;
    s.desc.current_time  = now_t;
    s.desc.active_block  = act;
    s.desc.final_block   = last;
    pending.push_back(s);
    items_queued++;
  endfunction

  function automatic void queue_write(logic [CFG_IDX_W-1:0] idx, logic [PG_W-1:0] val);
    step_t s;
    s.kind    = STEP_WRITE;
    s.reg_idx = idx;
    s.reg_val = val;
    pending.push_back(s);
  endfunction

  // sender holds off until every expected victim is in
  function automatic void queue_drain();
    step_t s;
    s.kind = STEP_DRAIN;
    pending.push_back(s);
  endfunction

  function automatic void queue_pace(int unsigned idle, int unsigned stall);
    step_t s;
    s.kind      = STEP_PACE;
    s.idle_pct  = idle;
    s.stall_pct = stall;
    pending.push_back(s);
  endfunction

  function automatic logic [PG_W-1:0] rand_pages();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 11'd1024;
      2:       return PG_W'($urandom_range(0, 3));
      3:       return PG_W'($urandom_range(1020, 1024));
      default: return PG_W'($urandom_range(0, 1024));
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // driver: feeds items and register writes from the work list
  always @(posedge clk) begin : feed_p
    step_t head;
    logic  nxt_valid;
    logic  nxt_we;
    logic  block_quiet;
    if (rst_n) begin
      nxt_valid = desc_if.valid;
      nxt_we    = 1'b0;
      if (desc_if.valid && desc_if.ready) begin
        predict_victim(desc_if.data);
        nxt_valid    = 1'b0;
        quiet_cycles = 0;
      end else if (quiet_cycles < 1000) begin
        quiet_cycles++;
      end
      // idle means no victim outstanding and the last item has worked through
      block_quiet = (victim_q.size() == 0) && (quiet_cycles >= SETTLE_CYCLES);
      if (!nxt_valid && pending.size() != 0) begin
        if (hold_cycles != 0) begin
          hold_cycles--;
        end else begin
          head = pending[0];
          case (head.kind)
            STEP_ITEM: begin
              if ($urandom_range(0, 99) >= idle_pct) begin
                desc_if.data <= head.desc;
                nxt_valid = 1'b1;
                void'(pending.pop_front());
              end
            end
            STEP_WRITE: begin
              if (block_quiet) begin
                nxt_we = 1'b1;
                cfg_idx  <= head.reg_idx;
                cfg_data <= head.reg_val;
                if (head.reg_idx == CFG_POLICY_MODE) mdl_mode = head.reg_val[0];
                else mdl_pages = head.reg_val;
                void'(pending.pop_front());
                // let the write land before the next item
                hold_cycles = 2;
              end
            end
            STEP_DRAIN: begin
              if (block_quiet) begin
                void'(pending.pop_front());
                hold_cycles = $urandom_range(0, 20);
              end
            end
            default: begin
              idle_pct  <= head.idle_pct;
              stall_pct <= head.stall_pct;
              void'(pending.pop_front());
            end
          endcase
        end
      end
      desc_if.valid <= nxt_valid;
      cfg_we        <= nxt_we;
    end
  end

  // monitor: checks each victim against the oldest prediction
  always @(posedge clk) begin : check_p
    out_item_t want;
    out_item_t got;
    if (rst_n) begin
      if (victim_if.valid && victim_if.ready) begin
        got = victim_if.data;
        if (victim_q.size() == 0) begin
          $display("%0t ns: unexpected victim, expected none, got found=%0b index=%0d",
                   $time, got.victim_found, got.victim_index);
          mismatches++;
        end else begin
          want = victim_q.pop_front();
          if (got.victim_found !== want.victim_found) begin
            $display("%0t ns: victim_found expected %0b got %0b",
                     $time, want.victim_found, got.victim_found);
            mismatches++;
          end
          if (got.victim_index !== want.victim_index) begin
            $display("%0t ns: victim_index expected %0d got %0d",
                     $time, want.victim_index, got.victim_index);
            mismatches++;
          end
        end
      end
      victim_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin : stim_p
    int unsigned       seg;
    int unsigned       scans;
    int unsigned       s;
    int unsigned       len;
    int                mid;
    int unsigned       b;
    logic [WORD_W-1:0] scan_now;
    logic [WORD_W-1:0] item_now;
    logic [WORD_W-1:0] age_t;
    logic [POS_W-1:0]  scan_act;
    logic [POS_W-1:0]  item_act;
    logic [PG_W-1:0]   cap_val;

    desc_if.valid   = 1'b0;
    desc_if.data    = '0;
    victim_if.ready = 1'b0;

    // directed scans, no idling
    queue_pace(0, 0);
    // greedy at reset: clean skip, active skip, first taken, ties on wear
    add_desc(1'b1, 11'd0, 11'd1024, 32'd0, 32'd0, 32'd0, 10'd2, 1'b0);
    add_desc(1'b0, 11'd10, 11'd5, 32'd7, 32'd0, 32'd0, 10'd2, 1'b0);
    add_desc(1'b0, 11'd0, 11'd1024, 32'd0, 32'd0, 32'd0, 10'd2, 1'b0);
    add_desc(1'b0, 11'd20, 11'd5, 32'd9, 32'd0, 32'd0, 10'd2, 1'b0);
    add_desc(1'b0, 11'd30, 11'd5, 32'd3, 32'd0, 32'd0, 10'd2, 1'b0);
    add_desc(1'b0, 11'd1024, 11'd1024, '1, '1, '1, 10'd2, 1'b0);
    add_desc(1'b0, 11'd1024, 11'd1024, '1, 32'd0, 32'd0, 10'd2, 1'b1);
    // scans where nothing qualifies
    add_desc(1'b1, 11'd5, 11'd5, 32'd0, 32'd0, 32'd0, 10'd1023, 1'b1);
    add_desc(1'b0, 11'd5, 11'd5, 32'd0, 32'd0, 32'd0, 10'd0, 1'b1);
    // cost-benefit with capacity 100
    queue_write(CFG_POLICY_MODE, PG_W'(POLICY_COST_BENEFIT));
    queue_write(CFG_PAGES_IN_BLOCK, 11'd100);
    add_desc(1'b0, 11'd50, 11'd0, 32'd5, 32'd900, 32'd1000, 10'd1023, 1'b0);
    add_desc(1'b0, 11'd50, 11'd0, 32'd5, 32'd900, 32'd1000, 10'd1023, 1'b0);
    add_desc(1'b0, 11'd25, 11'd0, 32'd5, 32'd900, 32'd1000, 10'd1023, 1'b0);
    // valid at capacity scores zero
    add_desc(1'b0, 11'd100, 11'd7, 32'd0, 32'd0, 32'd1000, 10'd1023, 1'b0);
    // no valid pages beats everything, then a tie among them on wear
    add_desc(1'b0, 11'd0, 11'd0, 32'd10, 32'd1000, 32'd1000, 10'd1023, 1'b0);
    add_desc(1'b0, 11'd0, 11'd0, 32'd2, 32'd1000, 32'd1000, 10'd1023, 1'b0);
    // age wraps around the time counter
    add_desc(1'b0, 11'd1024, 11'd1024, 32'd0, '1, 32'd1000, 10'd1023, 1'b1);
    // zero capacity: every block with valid pages scores zero
    queue_write(CFG_PAGES_IN_BLOCK, 11'd0);
    add_desc(1'b0, 11'd1, 11'd0, 32'd9, 32'd0, 32'd50, 10'd1023, 1'b0);
    add_desc(1'b0, 11'd1024, 11'd0, 32'd4, 32'd0, 32'd50, 10'd1023, 1'b0);
    add_desc(1'b0, 11'd3, 11'd0, 32'd4, 32'd0, 32'd50, 10'd1023, 1'b1);
    // capacity above the maximum clamps to it
    queue_write(CFG_PAGES_IN_BLOCK, 11'd2047);
    add_desc(1'b0, 11'd1000, 11'd0, 32'd0, 32'd0, 32'd10, 10'd1023, 1'b0);
    add_desc(1'b0, 11'd1024, 11'd0, 32'd0, 32'd0, 32'd10, 10'd1023, 1'b1);
    queue_drain();

    // random scans in segments, each with its own pacing and settings
    seg = 0;
    while (items_queued < ITEM_TARGET) begin
      case (seg % 4)
        0:       queue_pace(0, 0);
        1:       queue_pace(69, 0);
        2:       queue_pace(0, 69);
        default: queue_pace(25, 25);
      endcase
      queue_write(CFG_POLICY_MODE, PG_W'($urandom_range(0, 1)));
      case ($urandom_range(0, 8))
        0:       cap_val = 11'd0;
        1:       cap_val = 11'd1;
        2:       cap_val = 11'd2;
        3:       cap_val = 11'd256;
        4:       cap_val = 11'd1023;
        5:       cap_val = 11'd1024;
        6:       cap_val = 11'd1025;
        7:       cap_val = 11'd2047;
        default: cap_val = PG_W'($urandom_range(1, 1024));
      endcase
      queue_write(CFG_PAGES_IN_BLOCK, cap_val);
      scans = $urandom_range(3, 6);
      for (s = 0; s < scans; s++) begin
        // one scan long enough to wrap the position counter
        if (seg == 2 && s == 0) len = 1030;
        else if ($urandom_range(0, 7) == 0) len = $urandom_range(9, 40);
        else len = $urandom_range(1, 8);
        scan_now = rand_word();
        if ($urandom_range(0, 3) == 0) scan_act = POS_W'($urandom_range(0, 1023));
        else scan_act = POS_W'($urandom_range(0, (len > 1024) ? 3 : len - 1));
        mid = -1;
        if (len > 1 && $urandom_range(0, 4) == 0) mid = $urandom_range(1, len - 1);
        for (b = 0; b < len; b++) begin
          // mode write in the middle of a scan, block idle but scan state kept
          if (mid >= 0 && b == mid) begin
            queue_write(CFG_POLICY_MODE, PG_W'($urandom_range(0, 1)));
            if ($urandom_range(0, 1) == 0) queue_drain();
          end
          case ($urandom_range(0, 4))
            0:       age_t = '0;
            1:       age_t = $urandom_range(0, 3);
            2:       age_t = '1;
            default: age_t = $urandom;
          endcase
          // now and then a descriptor out of step with its scan
          item_now = ($urandom_range(0, 19) == 0) ? $urandom : scan_now;
          item_act = ($urandom_range(0, 19) == 0) ? POS_W'($urandom) : scan_act;
          add_desc($urandom_range(0, 6) == 0, rand_pages(), rand_pages(),
                   ($urandom_range(0, 1) == 0) ? WORD_W'($urandom_range(0, 3)) : rand_word(),
                   item_now - age_t, item_now, item_act, b == len - 1);
        end
        if ($urandom_range(0, 7) == 0) queue_drain();
      end
      seg++;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // settled values at the falling edge: all items taken, all victims in
    @(negedge clk);
    while (pending.size() != 0 || desc_if.valid || victim_q.size() != 0) @(negedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog_p
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* filelist.f */
rtl/gcvs_pkg.sv
rtl/gcvs_in_if.sv
rtl/gcvs_out_if.sv
rtl/gcvs_ctrl.sv
rtl/gcvs_dp.sv
rtl/gc_victim_block_selector.sv
bench/tb_gc_victim_block_selector.sv
